[hw/rtl/ics_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ics_pkg
// Shared types, constants and the one's complement add for the checksum block.
// ----------------------------------------------------------------------------
package ics_pkg;

    localparam int unsigned WORD_W       = 16;
    localparam int unsigned CKSUM_OFF_HI = 10;
    localparam int unsigned CKSUM_OFF_LO = 11;

    localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;

    localparam logic MODE_IP  = 1'b0;
    localparam logic MODE_TCP = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ODD_LEN = 1'b1;

    // Packet summary handed from the byte accumulator to the finishing stage.
    typedef struct packed {
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] pad;
        logic [WORD_W-1:0] len;
        logic [31:0]       src;
        logic [31:0]       dst;
        logic              mode;
        logic              err;
    } ics_fin_t;

    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ics_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ics_in_if
// Byte stream channel into the checksum block.
// ----------------------------------------------------------------------------
interface ics_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] src_ip;
    logic [31:0] dst_addr;

    modport source (output valid, cmd, data_byte, last, src_ip, dst_addr,
                    input ready);
    modport sink   (input valid, cmd, data_byte, last, src_ip, dst_addr,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/ics_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ics_out_if
// Result channel out of the checksum block.
// ----------------------------------------------------------------------------
interface ics_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic        status;

    modport source (output valid, checksum, status, input ready);
    modport sink   (input valid, checksum, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/internet_checksum_ip_tcp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// internet_checksum_ip_tcp
// One's complement checksum over a byte stream, for IPv4 headers or TCP.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on the pkt channel and accepts a byte in
// every cycle while the result path has room. Bytes pair big-endian into
// 16-bit words and go through one end-around-carry add per word. On the byte
// marked last, the packet sum moves to a finishing register; from there the
// complemented checksum is loaded into the output register when that register
// has room. Input stalls only while both the finishing register and the output
// register hold results that are not yet taken. In IP mode the bytes at
// offsets 10 and 11 count as zero and an odd length returns checksum 0 with
// status 1. In TCP mode an odd final byte is padded with zero and the
// pseudo-header (addresses, protocol 6, byte length) is added. Mode and
// addresses are taken from the first byte of each packet. The byte count
// wraps modulo 2^MAX_LEN_BITS.
// ----------------------------------------------------------------------------
module internet_checksum_ip_tcp
    import ics_pkg::*;
#(
    parameter int unsigned MAX_LEN_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ics_in_if.sink    pkt,
    ics_out_if.source res
);

    localparam logic [MAX_LEN_BITS-1:0] OFF_HI = MAX_LEN_BITS'(CKSUM_OFF_HI);
    localparam logic [MAX_LEN_BITS-1:0] OFF_LO = MAX_LEN_BITS'(CKSUM_OFF_LO);

    logic [15:0]             acc_reg;
    logic [MAX_LEN_BITS-1:0] count_reg;
    logic [7:0]              held_reg;
    logic                    mode_reg;
    logic [31:0]             src_reg;
    logic [31:0]             dst_reg;
    logic                    in_packet_reg;

    logic                    fin_valid_reg;
    ics_fin_t                fin_reg;
    logic                    fin_ready;

    logic                    take;
    logic                    mode_cur;
    logic [31:0]             src_cur;
    logic [31:0]             dst_cur;
    logic [7:0]              byte_cur;
    logic                    odd;
    logic [15:0]             acc_next;
    logic [MAX_LEN_BITS-1:0] count_next;
    ics_fin_t                fin_next;

    assign pkt.ready = !fin_valid_reg || fin_ready;
    assign take      = pkt.valid && pkt.ready;

    always_comb
    begin
        mode_cur = in_packet_reg ? mode_reg : pkt.cmd;
        src_cur  = in_packet_reg ? src_reg  : pkt.src_ip;
        dst_cur  = in_packet_reg ? dst_reg  : pkt.dst_addr;
        odd      = count_reg[0];

        // The checksum field of an IPv4 header is summed as zero.
        if (mode_cur == MODE_IP && (count_reg == OFF_HI || count_reg == OFF_LO))
        begin
            byte_cur = 8'h00;
        end
        else
        begin
            byte_cur = pkt.data_byte;
        end

        acc_next   = odd ? oc_add(acc_reg, {held_reg, byte_cur}) : acc_reg;
        count_next = count_reg + MAX_LEN_BITS'(1);

        fin_next.acc  = acc_next;
        fin_next.pad  = (mode_cur == MODE_TCP && !odd) ? {byte_cur, 8'h00} : 16'h0000;
        fin_next.len  = 16'(count_next);
        fin_next.src  = src_cur;
        fin_next.dst  = dst_cur;
        fin_next.mode = mode_cur;
        fin_next.err  = (mode_cur == MODE_IP) && !odd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            mode_reg      <= MODE_IP;
            src_reg       <= '0;
            dst_reg       <= '0;
            in_packet_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_cur;
            src_reg  <= src_cur;
            dst_reg  <= dst_cur;
            if (pkt.last)
            begin
                acc_reg       <= '0;
                count_reg     <= '0;
                held_reg      <= '0;
                in_packet_reg <= 1'b0;
            end
            else
            begin
                acc_reg       <= acc_next;
                count_reg     <= count_next;
                held_reg      <= odd ? held_reg : byte_cur;
                in_packet_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (take && pkt.last)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_ready)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pkt.last)
        begin
            fin_reg <= fin_next;
        end
    end

    ics_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid_reg),
        .fin       (fin_reg),
        .fin_ready (fin_ready),
        .res       (res)
    );

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && pkt.last |=> !in_packet_reg && count_reg == '0 && acc_reg == '0)
        else $error("packet state not cleared after last byte");

    a_count_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> in_packet_reg)
        else $error("byte count outside a packet");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !fin_ready |=> fin_valid_reg && $stable(fin_reg))
        else $error("finishing register changed while stalled");

endmodule
`default_nettype wire

[hw/rtl/ics_finish.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ics_finish
// Adds the pad word and, for TCP, the pseudo-header to a packet sum, folds the
// carries and holds the complemented checksum in the output register.
// ----------------------------------------------------------------------------
module ics_finish
    import ics_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fin_valid,
    input  wire ics_fin_t fin,
    output logic          fin_ready,
    ics_out_if.source     res
);

    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic        status_reg;

    logic [18:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] checksum_next;

    assign fin_ready = !out_valid_reg || res.ready;

    // Wide sum of up to eight words; two folds give the same result as a
    // chain of end-around-carry adds.
    always_comb
    begin
        sum = 19'(fin.acc) + 19'(fin.pad);
        if (fin.mode == MODE_TCP)
        begin
            sum = sum + 19'(fin.src[31:16]) + 19'(fin.src[15:0])
                      + 19'(fin.dst[31:16]) + 19'(fin.dst[15:0])
                      + 19'(PROTO_TCP) + 19'(fin.len);
        end
        fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        checksum_next = fin.err ? 16'h0000 : ~fold2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && fin_valid)
        begin
            checksum_reg <= checksum_next;
            status_reg   <= fin.err ? STATUS_ODD_LEN : STATUS_OK;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.checksum = checksum_reg;
    assign res.status   = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_ODD_LEN |-> checksum_reg == 16'h0000)
        else $error("error status without zero checksum");

    a_load_on_room: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && fin_ready |=> out_valid_reg)
        else $error("finished packet lost at output register");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(checksum_reg))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

[dv/internet_checksum_ip_tcp_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// internet_checksum_ip_tcp_test
// Self-checking bench for the IPv4/TCP checksum block. A byte driver and a
// result monitor run against a byte-level model of the one's complement sum.
// Coverage includes IP and TCP packets, odd lengths, the skipped checksum
// field and the pseudo-header.
// ----------------------------------------------------------------------------
module internet_checksum_ip_tcp_test;
    import ics_pkg::*;

    localparam int unsigned LEN_BITS     = 16;
    localparam int unsigned RANDOM_BYTES = 1650;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned IDLE_PCT     = 24;
    localparam int unsigned MAX_PRINTED  = 30;
    localparam int unsigned STEADY_FROM  = 800;
    localparam int unsigned STEADY_TO    = 1400;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] src_ip;
        logic [31:0] dst_addr;
    } pkt_byte_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic        status;
    } cksum_t;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ics_in_if  pkt_if ();
    ics_out_if res_if ();

    internet_checksum_ip_tcp #(.MAX_LEN_BITS(LEN_BITS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if),
        .res   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pkt_byte_t byte_queue[$];
    cksum_t    cksum_expected[$];

    // Model of the packet state.
    logic [15:0] sum_acc   = '0;
    logic [15:0] len_count = '0;
    logic [7:0]  high_byte = '0;
    logic        mode_q    = MODE_IP;
    logic [31:0] src_q     = '0;
    logic [31:0] dst_q     = '0;
    logic        in_pkt    = 1'b0;

    int unsigned bytes_queued    = 0;
    int unsigned bytes_taken_cnt = 0;
    int unsigned results_checked = 0;
    int unsigned ip_packets      = 0;
    int unsigned tcp_packets     = 0;
    int unsigned odd_errors      = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_no        = 0;
    int unsigned quiet_cycles    = 0;
    logic        byte_taken      = 1'b0;
    logic        no_idle;

    assign no_idle = (cycle_no >= STEADY_FROM) && (cycle_no < STEADY_TO);

    function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return {15'b0, s[16]} + s[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic predict_byte(input pkt_byte_t b);
        logic [15:0] off;
        logic [7:0]  v;
        cksum_t      r;
        if (!in_pkt)
        begin
            mode_q = b.cmd;
            src_q  = b.src_ip;
            dst_q  = b.dst_addr;
            in_pkt = 1'b1;
        end
        off = len_count;
        v   = b.data_byte;
        // The checksum field of an IPv4 header is summed as zero.
        if (mode_q == MODE_IP && (off == CKSUM_OFF_HI || off == CKSUM_OFF_LO))
            v = 8'h00;
        if (!off[0])
            high_byte = v;
        else
            sum_acc = ones_sum(sum_acc, {high_byte, v});
        len_count = off + 16'd1;
        if (b.last)
        begin
            if (!off[0] && mode_q == MODE_IP)
            begin
                r.checksum = 16'h0000;
                r.status   = STATUS_ODD_LEN;
                odd_errors++;
            end
            else
            begin
                if (!off[0])
                    sum_acc = ones_sum(sum_acc, {v, 8'h00});
                if (mode_q == MODE_TCP)
                begin
                    sum_acc = ones_sum(sum_acc, src_q[31:16]);
                    sum_acc = ones_sum(sum_acc, src_q[15:0]);
                    sum_acc = ones_sum(sum_acc, dst_q[31:16]);
                    sum_acc = ones_sum(sum_acc, dst_q[15:0]);
                    sum_acc = ones_sum(sum_acc, PROTO_TCP);
                    sum_acc = ones_sum(sum_acc, len_count);
                    tcp_packets++;
                end
                else
                    ip_packets++;
                r.checksum = ~sum_acc;
                r.status   = STATUS_OK;
            end
            cksum_expected.push_back(r);
            sum_acc   = '0;
            len_count = '0;
            high_byte = '0;
            in_pkt    = 1'b0;
        end
    endtask

    task automatic queue_byte(input logic cmd, input logic [7:0] d, input logic last,
                              input logic [31:0] s, input logic [31:0] t);
        pkt_byte_t nb;
        nb.cmd       = cmd;
        nb.data_byte = d;
        nb.last      = last;
        nb.src_ip    = s;
        nb.dst_addr  = t;
        byte_queue.push_back(nb);
        bytes_queued++;
    endtask

    // Mode and addresses matter only on the first byte; later bytes carry noise.
    task automatic queue_packet(input logic mode, input int unsigned len, input fill_t fill,
                                input logic [31:0] s, input logic [31:0] t);
        logic [7:0] d;
        for (int unsigned i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: d = 8'h00;
                FILL_ONES: d = 8'hff;
                default:   d = 8'($urandom_range(255));
            endcase
            if (i == 0)
                queue_byte(mode, d, len == 1, s, t);
            else
                queue_byte(1'($urandom_range(1)), d, i == len - 1, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_addr();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 32'hffff_ffff;
        else if (sel < 20)
            return 32'h0000_0000;
        return $urandom;
    endfunction

    task automatic wait_drained();
        while (bytes_taken_cnt != bytes_queued || cksum_expected.size() != 0)
            @(posedge clk);
    endtask

    // Monitor: prediction on accepted bytes, comparison on accepted results.
    always @(posedge clk)
    begin
        pkt_byte_t seen;
        cksum_t    want;
        byte_taken <= pkt_if.valid && pkt_if.ready;
        if (rst_n)
        begin
            cycle_no++;
            if (pkt_if.valid && pkt_if.ready)
            begin
                seen.cmd       = pkt_if.cmd;
                seen.data_byte = pkt_if.data_byte;
                seen.last      = pkt_if.last;
                seen.src_ip    = pkt_if.src_ip;
                seen.dst_addr  = pkt_if.dst_addr;
                predict_byte(seen);
                bytes_taken_cnt++;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (cksum_expected.size() == 0)
                    report_mismatch("unexpected result", 32'(res_if.checksum), 32'h0);
                else
                begin
                    want = cksum_expected.pop_front();
                    results_checked++;
                    if (res_if.checksum !== want.checksum)
                        report_mismatch("checksum", 32'(res_if.checksum),
                                        32'(want.checksum));
                    if (res_if.status !== want.status)
                        report_mismatch("status", 32'(res_if.status), 32'(want.status));
                end
            end
        end
    end

    // Driver: a byte is held until taken; inputs move on the falling edge.
    always @(negedge clk)
    begin
        pkt_byte_t nxt;
        if (rst_n)
        begin
            res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if (!pkt_if.valid || byte_taken)
            begin
                if (byte_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = byte_queue.pop_front();
                    pkt_if.valid     <= 1'b1;
                    pkt_if.cmd       <= nxt.cmd;
                    pkt_if.data_byte <= nxt.data_byte;
                    pkt_if.last      <= nxt.last;
                    pkt_if.src_ip    <= nxt.src_ip;
                    pkt_if.dst_addr  <= nxt.dst_addr;
                end
                else
                    pkt_if.valid <= 1'b0;
            end
        end
    end

    // Watchdog: too many cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned start_count;
        int unsigned len;
        logic        mode;
        fill_t       fill;

        pkt_if.valid     = 1'b0;
        pkt_if.cmd       = MODE_IP;
        pkt_if.data_byte = 8'h00;
        pkt_if.last      = 1'b0;
        pkt_if.src_ip    = 32'h0;
        pkt_if.dst_addr  = 32'h0;
        res_if.ready     = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed packets: single bytes, extremes, checksum field, odd lengths.
        queue_packet(MODE_IP,  1,  FILL_ONES,   32'hffff_ffff, 32'hffff_ffff);
        queue_packet(MODE_TCP, 1,  FILL_ONES,   32'hffff_ffff, 32'hffff_ffff);
        queue_packet(MODE_IP,  2,  FILL_ZERO,   32'h0,         32'h0);
        queue_packet(MODE_IP,  12, FILL_ONES,   $urandom,      $urandom);
        queue_packet(MODE_IP,  3,  FILL_RANDOM, $urandom,      $urandom);
        queue_packet(MODE_TCP, 3,  FILL_ZERO,   32'h0,         32'h0);
        queue_packet(MODE_TCP, 2,  FILL_ONES,   32'hffff_ffff, 32'h0);

        // Hold off the random traffic until the directed results are all in.
        wait_drained();

        start_count = bytes_queued;
        while (bytes_queued - start_count < RANDOM_BYTES)
        begin
            mode = 1'($urandom_range(1));
            if ($urandom_range(99) < 70)
                len = (mode == MODE_IP) ? 20 + 4 * $urandom_range(10) : 20 + $urandom_range(60);
            else
                len = $urandom_range(40, 1);
            fill = ($urandom_range(99) < 8) ? FILL_ONES : FILL_RANDOM;
            queue_packet(mode, len, fill, pick_addr(), pick_addr());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes: %0d IP and %0d TCP checksums, %0d odd IP lengths.",
                 bytes_taken_cnt, ip_packets, tcp_packets, odd_errors);
        $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[internet_checksum_ip_tcp.f]
hw/rtl/ics_pkg.sv
hw/rtl/ics_in_if.sv
hw/rtl/ics_out_if.sv
hw/rtl/ics_finish.sv
hw/rtl/internet_checksum_ip_tcp.sv
dv/internet_checksum_ip_tcp_test.sv
